// ===== design/assert_macros.svh =====
// Assertion macros shared by the RTL of the per-key report backoff table.
// Needs nothing else; the bodies compile away when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Checked on every clock edge outside reset.
`define PKBT_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Checked on every clock edge, reset included.
`define PKBT_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define PKBT_ASSERT(lbl, clk, rst, prop, msg)
`define PKBT_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

// ===== design/pkbt_pkg.sv =====
// Package of the per-key report backoff table: sizes, codes and the
// command and status types between controller and datapath. No dependencies.
`default_nettype none
package pkbt_pkg;
   localparam int TABLE_DEPTH   = 1024;
   localparam int IDX_BITS      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CNT_BITS      = $clog2(TABLE_DEPTH + 1);
   localparam int TIME_BITS     = 32;
   localparam int KEY_BITS      = 22;
   localparam int BACKOFF_BITS  = 16;
   localparam int ENTRY_BITS    = KEY_BITS + TIME_BITS;
   localparam int CSR_ADDR_BITS = 3;
   localparam int CSR_DATA_BITS = 32;

   localparam logic [BACKOFF_BITS-1:0] BACKOFF_RESET = BACKOFF_BITS'(180);

   // Register index, taken from the word address bit of the byte address.
   localparam logic REG_BACKOFF = 1'b0;

   localparam logic [1:0] OUTCOME_SUPPRESSED = 2'd0;
   localparam logic [1:0] OUTCOME_RENEWED    = 2'd1;
   localparam logic [1:0] OUTCOME_NEW_STORED = 2'd2;
   localparam logic [1:0] OUTCOME_TABLE_FULL = 2'd3;

   typedef struct packed {
      logic start;   // latch the request and restart the scan
      logic step;    // issue the next table read and advance the compare stage
      logic commit;  // settle the outcome, update the table, load the result
   } cmd_type;

   typedef struct packed {
      logic hit;     // the entry in the compare stage holds the request key
      logic chk_vld; // the compare stage holds read data
      logic more;    // filled entries remain to be read
   } stat_type;
endpackage
`default_nettype wire

// ===== design/pkbt_intf.sv =====
// Handshake interfaces of the request and response channels.
// Depends on pkbt_pkg for the field widths.
`default_nettype none
interface pkbt_req_if;
   logic                               valid;
   logic                               ready;
   logic [pkbt_pkg::KEY_BITS-1:0]      key;
   logic [pkbt_pkg::TIME_BITS-1:0]     now_time;
   modport source (output valid, key, now_time, input ready);
   modport sink (input valid, key, now_time, output ready);
endinterface

interface pkbt_rsp_if;
   logic       valid;
   logic       ready;
   logic       allow;
   logic [1:0] outcome;
   modport source (output valid, allow, outcome, input ready);
   modport sink (input valid, allow, outcome, output ready);
endinterface
`default_nettype wire

// ===== design/pkbt_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`default_nettype none
module pkbt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic                 clock,
   input  wire logic                 wr_en,
   input  wire logic [ADDR_BITS-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]     wr_data,
   input  wire logic                 rd_en,
   input  wire logic [ADDR_BITS-1:0] rd_addr,
   output logic      [WIDTH-1:0]     rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule
`default_nettype wire

// ===== design/pkbt_datapath.sv =====
// Datapath of the backoff table: request latch, scan counters, table RAM,
// elapsed-time check, fill count, backoff register and result register.
// Depends on pkbt_pkg and pkbt_ram.
`default_nettype none
module pkbt_datapath (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire pkbt_pkg::cmd_type                    cmd,
   output pkbt_pkg::stat_type                        stat,
   input  wire logic [pkbt_pkg::KEY_BITS-1:0]        req_key,
   input  wire logic [pkbt_pkg::TIME_BITS-1:0]       req_now_time,
   input  wire logic                                 csr_wr_en,
   input  wire logic [pkbt_pkg::BACKOFF_BITS-1:0]    csr_wdata,
   output logic      [pkbt_pkg::BACKOFF_BITS-1:0]    backoff,
   output logic                                      rsp_allow,
   output logic      [1:0]                           rsp_outcome
);
   localparam int IDX_BITS  = pkbt_pkg::IDX_BITS;
   localparam int CNT_BITS  = pkbt_pkg::CNT_BITS;
   localparam int TIME_BITS = pkbt_pkg::TIME_BITS;
   localparam int KEY_BITS  = pkbt_pkg::KEY_BITS;

   logic [KEY_BITS-1:0]               key_ff;
   logic [TIME_BITS-1:0]              time_ff;
   logic [CNT_BITS-1:0]               issue_ff, issue_in;
   logic                              chk_vld_ff, chk_vld_in;
   logic [IDX_BITS-1:0]               chk_idx_ff, chk_idx_in;
   logic [CNT_BITS-1:0]               filled_ff, filled_in;
   logic [pkbt_pkg::BACKOFF_BITS-1:0] backoff_ff, backoff_in;
   logic                              allow_ff, allow_in;
   logic [1:0]                        outcome_ff, outcome_in;

   logic                              more;
   logic                              hit;
   logic                              full;
   logic                              renew_ok;
   logic [TIME_BITS-1:0]              elapsed;
   logic                              rd_en;
   logic                              wr_en;
   logic [IDX_BITS-1:0]               wr_addr;
   logic [pkbt_pkg::ENTRY_BITS-1:0]   rd_data;
   logic [KEY_BITS-1:0]               rd_key;
   logic [TIME_BITS-1:0]              rd_time;

   pkbt_ram #(
      .WIDTH (pkbt_pkg::ENTRY_BITS),
      .DEPTH (pkbt_pkg::TABLE_DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data ({key_ff, time_ff}),
      .rd_en   (rd_en),
      .rd_addr (issue_ff[IDX_BITS-1:0]),
      .rd_data (rd_data)
   );

   assign rd_key  = rd_data[pkbt_pkg::ENTRY_BITS-1:TIME_BITS];
   assign rd_time = rd_data[TIME_BITS-1:0];

   assign more     = (issue_ff < filled_ff);
   assign hit      = chk_vld_ff && (rd_key == key_ff);
   assign full     = (filled_ff == CNT_BITS'(pkbt_pkg::TABLE_DEPTH));
   // Modular difference; a timestamp that went backwards looks like a long wait.
   assign elapsed  = time_ff - rd_time;
   assign renew_ok = (elapsed >= {{(TIME_BITS - pkbt_pkg::BACKOFF_BITS){1'b0}}, backoff_ff});
   assign rd_en    = cmd.step && more;
   assign wr_en    = cmd.commit && (hit ? renew_ok : !full);
   assign wr_addr  = hit ? chk_idx_ff : filled_ff[IDX_BITS-1:0];

   always_comb begin
      issue_in   = issue_ff;
      chk_vld_in = chk_vld_ff;
      chk_idx_in = chk_idx_ff;
      filled_in  = filled_ff;
      backoff_in = csr_wr_en ? csr_wdata : backoff_ff;
      allow_in   = allow_ff;
      outcome_in = outcome_ff;
      if (cmd.start) begin
         issue_in   = '0;
         chk_vld_in = 1'b0;
      end else if (cmd.step) begin
         chk_vld_in = more;
         chk_idx_in = issue_ff[IDX_BITS-1:0];
         if (more) begin
            issue_in = issue_ff + CNT_BITS'(1);
         end
      end
      if (cmd.commit) begin
         if (hit) begin
            allow_in   = renew_ok;
            outcome_in = renew_ok ? pkbt_pkg::OUTCOME_RENEWED
                                  : pkbt_pkg::OUTCOME_SUPPRESSED;
         end else if (!full) begin
            allow_in   = 1'b1;
            outcome_in = pkbt_pkg::OUTCOME_NEW_STORED;
            filled_in  = filled_ff + CNT_BITS'(1);
         end else begin
            allow_in   = 1'b1;
            outcome_in = pkbt_pkg::OUTCOME_TABLE_FULL;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         issue_ff   <= '0;
         chk_vld_ff <= 1'b0;
         filled_ff  <= '0;
         backoff_ff <= pkbt_pkg::BACKOFF_RESET;
      end else begin
         issue_ff   <= issue_in;
         chk_vld_ff <= chk_vld_in;
         filled_ff  <= filled_in;
         backoff_ff <= backoff_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         key_ff  <= req_key;
         time_ff <= req_now_time;
      end
      chk_idx_ff <= chk_idx_in;
      allow_ff   <= allow_in;
      outcome_ff <= outcome_in;
   end

   assign stat.hit     = hit;
   assign stat.chk_vld = chk_vld_ff;
   assign stat.more    = more;
   assign backoff      = backoff_ff;
   assign rsp_allow    = allow_ff;
   assign rsp_outcome  = outcome_ff;
endmodule
`default_nettype wire

// ===== design/pkbt_ctrl.sv =====
// Controller of the backoff table: sequences the scan and the commit and
// owns the handshake state of both channels. Depends on pkbt_pkg.
`default_nettype none
module pkbt_ctrl (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output pkbt_pkg::cmd_type      cmd,
   input  wire pkbt_pkg::stat_type stat
);
   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_SCAN   = 2'd1;
   localparam logic [1:0] ST_COMMIT = 2'd2;

   logic [1:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       out_free;

   // The result register may be reloaded once its transaction has gone.
   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in   = state_ff;
      req_ready  = 1'b0;
      cmd.start  = 1'b0;
      cmd.step   = 1'b0;
      cmd.commit = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.start = 1'b1;
               state_in  = ST_SCAN;
            end
         end
         ST_SCAN: begin
            // Stop on the first match, or once the read pipeline has drained.
            if (stat.hit || (!stat.chk_vld && !stat.more)) begin
               state_in = ST_COMMIT;
            end else begin
               cmd.step = 1'b1;
            end
         end
         ST_COMMIT: begin
            if (out_free) begin
               cmd.commit = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
endmodule
`default_nettype wire

// ===== design/per_key_report_backoff_table.sv =====
// Per-key report backoff table. A request is taken only while no other is in
// work; its result is loaded once the linear scan, which reads one table entry
// per cycle through the RAM's single read port, has met the key or passed every
// filled entry and the result register is free. The next request is taken in
// the cycle after the result is loaded. Reset empties the table and sets the
// backoff to 180.
`include "assert_macros.svh"
`default_nettype none
module per_key_report_backoff_table (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   pkbt_req_if.sink                                   req,
   pkbt_rsp_if.source                                 rsp,
   input  wire logic                                  csr_psel,
   input  wire logic                                  csr_penable,
   input  wire logic                                  csr_pwrite,
   input  wire logic [pkbt_pkg::CSR_ADDR_BITS-1:0]    csr_paddr,
   input  wire logic [pkbt_pkg::CSR_DATA_BITS-1:0]    csr_pwdata,
   output logic      [pkbt_pkg::CSR_DATA_BITS-1:0]    csr_prdata,
   output logic                                       csr_pready
);
   pkbt_pkg::cmd_type                  cmd;
   pkbt_pkg::stat_type                 stat;
   logic                               csr_wr_en;
   logic                               csr_sel_backoff;
   logic [pkbt_pkg::BACKOFF_BITS-1:0]  backoff;

   // Registers sit on word addresses; the low two bits are ignored.
   assign csr_sel_backoff = (csr_paddr[2] == pkbt_pkg::REG_BACKOFF);
   assign csr_pready      = 1'b1;
   assign csr_wr_en       = csr_psel && csr_penable && csr_pwrite && csr_sel_backoff;
   assign csr_prdata      = csr_sel_backoff
      ? {{(pkbt_pkg::CSR_DATA_BITS - pkbt_pkg::BACKOFF_BITS){1'b0}}, backoff}
      : '0;

   pkbt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_ready (req.ready),
      .rsp_valid (rsp.valid),
      .rsp_ready (rsp.ready),
      .cmd       (cmd),
      .stat      (stat)
   );

   pkbt_datapath u_datapath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .stat         (stat),
      .req_key      (req.key),
      .req_now_time (req.now_time),
      .csr_wr_en    (csr_wr_en),
      .csr_wdata    (csr_pwdata[pkbt_pkg::BACKOFF_BITS-1:0]),
      .backoff      (backoff),
      .rsp_allow    (rsp.allow),
      .rsp_outcome  (rsp.outcome)
   );

   `PKBT_ASSERT(a_commit_room, clock, reset, cmd.commit |-> (!rsp.valid || rsp.ready), "result register overwritten before its transaction")
   `PKBT_ASSERT(a_no_accept_in_scan, clock, reset, cmd.step |-> !req.ready, "request accepted while a scan is in progress")
   `PKBT_ASSERT(a_commit_once, clock, reset, cmd.commit |=> !cmd.commit, "two commits for one request")
   `PKBT_ASSERT_ALWAYS(a_reset_idle, clock, $past(reset) |-> !rsp.valid, "response valid straight after reset")
endmodule
`default_nettype wire

// ===== sim/per_key_report_backoff_table_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench of per_key_report_backoff_table: requests with random
// idling and backoff changes over the APB-style port.
// Depends on pkbt_pkg, the request and response interfaces and the RTL.
module per_key_report_backoff_table_tb;
   localparam int KEY_BITS      = pkbt_pkg::KEY_BITS;
   localparam int TIME_BITS     = pkbt_pkg::TIME_BITS;
   localparam int BACKOFF_BITS  = pkbt_pkg::BACKOFF_BITS;
   localparam int TABLE_DEPTH   = pkbt_pkg::TABLE_DEPTH;
   localparam int CSR_ADDR_BITS = pkbt_pkg::CSR_ADDR_BITS;
   localparam int CSR_DATA_BITS = pkbt_pkg::CSR_DATA_BITS;

   localparam logic [CSR_ADDR_BITS-1:0] BACKOFF_ADDR = {pkbt_pkg::REG_BACKOFF, 2'b00};
   localparam logic [CSR_ADDR_BITS-1:0] SPARE_ADDR   = {~pkbt_pkg::REG_BACKOFF, 2'b00};
   localparam int QUIET_CYCLES  = 8;
   localparam int HOLD_CYCLES   = 1500;
   localparam int POOL_SIZE     = 48;
   localparam int HOT_KEYS      = 6;
   localparam int PHASE_ITEMS   = 113;

   typedef struct packed {
      logic       allow;
      logic [1:0] outcome;
   } verdict_type;

   // Mirror of the table that predicts each verdict and checks responses in order.
   class backoff_scoreboard;
      bit [KEY_BITS-1:0]     slot_key   [TABLE_DEPTH];
      bit [TIME_BITS-1:0]    slot_stamp [TABLE_DEPTH];
      int                    filled;
      bit [BACKOFF_BITS-1:0] backoff;
      verdict_type           awaited[$];
      int unsigned           mismatches;
      int unsigned           tally[4];

      function void restart();
         filled  = 0;
         backoff = pkbt_pkg::BACKOFF_RESET;
         awaited.delete();
      endfunction

      function int find_slot(bit [KEY_BITS-1:0] key);
         for (int i = 0; i < filled; i++)
            if (slot_key[i] == key)
               return i;
         return -1;
      endfunction

      function verdict_type predict_verdict(bit [KEY_BITS-1:0] key,
                                            bit [TIME_BITS-1:0] stamp);
         verdict_type        v;
         bit [TIME_BITS-1:0] elapsed;
         int                 slot;
         slot = find_slot(key);
         if (slot >= 0) begin
            // Elapsed time wraps modulo 2^32, so a step backwards looks very old.
            elapsed = stamp - slot_stamp[slot];
            if (elapsed < backoff) begin
               v.allow   = 1'b0;
               v.outcome = pkbt_pkg::OUTCOME_SUPPRESSED;
            end else begin
               slot_stamp[slot] = stamp;
               v.allow          = 1'b1;
               v.outcome        = pkbt_pkg::OUTCOME_RENEWED;
            end
         end else if (filled < TABLE_DEPTH) begin
            slot_key[filled]   = key;
            slot_stamp[filled] = stamp;
            filled++;
            v.allow   = 1'b1;
            v.outcome = pkbt_pkg::OUTCOME_NEW_STORED;
         end else begin
            v.allow   = 1'b1;
            v.outcome = pkbt_pkg::OUTCOME_TABLE_FULL;
         end
         return v;
      endfunction

      function void note_request(bit [KEY_BITS-1:0] key, bit [TIME_BITS-1:0] stamp);
         awaited.push_back(predict_verdict(key, stamp));
      endfunction

      function void check_result(logic allow, logic [1:0] outcome);
         verdict_type want;
         if (awaited.size() == 0) begin
            $error("response with nothing outstanding: allow %0b, outcome %0d", allow, outcome);
            mismatches++;
            return;
         end
         want = awaited.pop_front();
         tally[want.outcome]++;
         if (allow !== want.allow) begin
            $error("allow: expected %0b, actual %0b", want.allow, allow);
            mismatches++;
         end
         if (outcome !== want.outcome) begin
            $error("outcome: expected %0d, actual %0d", want.outcome, outcome);
            mismatches++;
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset;
   logic                     csr_psel;
   logic                     csr_penable;
   logic                     csr_pwrite;
   logic [CSR_ADDR_BITS-1:0] csr_paddr;
   logic [CSR_DATA_BITS-1:0] csr_pwdata;
   logic [CSR_DATA_BITS-1:0] csr_prdata;
   logic                     csr_pready;

   pkbt_req_if req_if ();
   pkbt_rsp_if rsp_if ();

   per_key_report_backoff_table dut (
      .clock       (clock),
      .reset       (reset),
      .req         (req_if),
      .rsp         (rsp_if),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   backoff_scoreboard     sb;
   bit [TIME_BITS-1:0]    epoch;
   bit [KEY_BITS-1:0]     key_pool[POOL_SIZE];
   bit                    steady;
   bit                    long_hold;
   int unsigned           csr_faults;
   int unsigned           settings_used;

   always #10 clock = ~clock;

   // Both channels and the register port are sampled at the rising edge.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_if.valid && req_if.ready)
            sb.note_request(req_if.key, req_if.now_time);
         if (rsp_if.valid && rsp_if.ready)
            sb.check_result(rsp_if.allow, rsp_if.outcome);
      end
   end

   // Response side: random back-pressure, a long hold when asked for, or always ready when steady.
   initial begin
      rsp_if.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (long_hold) begin
            long_hold    = 1'b0;
            rsp_if.ready = 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
         end else if (steady) begin
            rsp_if.ready = 1'b1;
         end else begin
            rsp_if.ready = ($urandom_range(99) >= 21);
         end
      end
   end

   task automatic send_request(input bit [KEY_BITS-1:0] key, input bit [TIME_BITS-1:0] stamp);
      @(negedge clock);
      if (!steady) begin
         while ($urandom_range(99) < 21) begin
            req_if.valid = 1'b0;
            @(negedge clock);
         end
      end
      req_if.valid    = 1'b1;
      req_if.key      = key;
      req_if.now_time = stamp;
      do @(posedge clock); while (!req_if.ready);
   endtask

   // Lets the block fall idle: no request offered and every response back.
   task automatic settle();
      @(negedge clock);
      req_if.valid = 1'b0;
      while (sb.awaited.size() != 0) @(negedge clock);
      repeat (QUIET_CYCLES) @(negedge clock);
   endtask

   task automatic csr_write(input logic [CSR_ADDR_BITS-1:0] addr,
                            input logic [CSR_DATA_BITS-1:0] data);
      @(negedge clock);
      csr_psel    = 1'b1;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b1;
      csr_paddr   = addr;
      csr_pwdata  = data;
      @(negedge clock);
      csr_penable = 1'b1;
      do @(posedge clock); while (!csr_pready);
      @(negedge clock);
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      if (addr[2] == pkbt_pkg::REG_BACKOFF)
         sb.backoff = data[BACKOFF_BITS-1:0];
   endtask

   task automatic csr_check_backoff();
      logic [CSR_DATA_BITS-1:0] seen;
      @(negedge clock);
      csr_psel    = 1'b1;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      csr_paddr   = BACKOFF_ADDR;
      @(negedge clock);
      csr_penable = 1'b1;
      do @(posedge clock); while (!csr_pready);
      seen = csr_prdata;
      @(negedge clock);
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      if (seen[BACKOFF_BITS-1:0] !== sb.backoff) begin
         $error("backoff_seconds: expected %0d, actual %0d", sb.backoff,
                seen[BACKOFF_BITS-1:0]);
         csr_faults++;
      end
   endtask

   // Upper data bits are random; only the low sixteen belong to the register.
   task automatic set_backoff(input bit [BACKOFF_BITS-1:0] value);
      settle();
      csr_write(BACKOFF_ADDR, {16'($urandom), value});
      csr_check_backoff();
      settings_used++;
   endtask

   function automatic bit [KEY_BITS-1:0] fresh_key();
      bit [KEY_BITS-1:0] k;
      do k = KEY_BITS'($urandom); while (sb.find_slot(k) >= 0);
      return k;
   endfunction

   // Small steps relative to the backoff keep hot keys suppressed and others
   // renewed; the odd step backwards or huge jump exercises the wrap.
   task automatic advance_epoch();
      int unsigned r;
      r = $urandom_range(99);
      if (r < 3)
         epoch -= $urandom_range(1, 2000);
      else if (r < 6)
         epoch += $urandom;
      else
         epoch += $urandom_range(0, int'(sb.backoff) / 16 + 1);
   endtask

   task automatic run_mixed_phase(input int count);
      int unsigned       r;
      bit [KEY_BITS-1:0] key;
      for (int i = 0; i < count; i++) begin
         advance_epoch();
         r = $urandom_range(99);
         if (r < 10)
            key = fresh_key();
         else if (r < 55)
            key = key_pool[$urandom_range(HOT_KEYS - 1)];
         else
            key = key_pool[$urandom_range(POOL_SIZE - 1, HOT_KEYS)];
         send_request(key, epoch);
      end
   endtask

   initial begin
      sb = new;
      sb.restart();
      reset           = 1'b1;
      req_if.valid    = 1'b0;
      req_if.key      = '0;
      req_if.now_time = '0;
      csr_psel        = 1'b0;
      csr_penable     = 1'b0;
      csr_pwrite      = 1'b0;
      csr_paddr       = '0;
      csr_pwdata      = '0;
      steady          = 1'b0;
      long_hold       = 1'b0;
      csr_faults      = 0;
      settings_used   = 1;
      for (int i = 0; i < POOL_SIZE; i++)
         key_pool[i] = KEY_BITS'($urandom);
      repeat (5) @(negedge clock);
      reset = 1'b0;

      csr_check_backoff();

      // Directed: boundaries of the backoff, wrap of the timestamp, extreme keys.
      send_request(22'h000000, 32'h0000_0000);
      send_request(22'h3FFFFF, 32'hFFFF_FFFF);
      send_request(22'h000000, 32'd179);
      send_request(22'h000000, 32'd180);
      send_request(22'h3FFFFF, 32'h0000_0000);
      send_request(22'h3FFFFF, 32'd179);
      send_request(22'h000000, 32'd100);
      send_request(22'h2AAAAA, 32'h5555_5555);
      send_request(22'h155555, 32'hAAAA_AAAA);
      send_request(22'h2AAAAA, 32'h5555_5555 + 32'd179);
      settle();
      // A write to the spare register index must leave the backoff alone.
      csr_write(SPARE_ADDR, 32'hFFFF_1234);
      csr_check_backoff();
      set_backoff(16'd0);
      send_request(22'h155555, 32'hAAAA_AAAA);
      set_backoff(16'hFFFF);
      send_request(22'h155555, 32'hAAAA_AAAA + 32'd65534);
      send_request(22'h155555, 32'hAAAA_AAAA + 32'd65535);
      send_request(22'h000000, 32'd100);

      epoch = 32'hFFFF_F000;
      set_backoff(16'd1);
      run_mixed_phase(PHASE_ITEMS);
      set_backoff(16'($urandom));
      long_hold = 1'b1;
      run_mixed_phase(PHASE_ITEMS);
      set_backoff(16'hFFFF);
      run_mixed_phase(PHASE_ITEMS);
      set_backoff(16'd0);
      steady = 1'b1;
      run_mixed_phase(PHASE_ITEMS);
      steady = 1'b0;
      set_backoff(16'($urandom_range(300)));
      run_mixed_phase(PHASE_ITEMS);
      settle();

      $display("Checked %0d suppressed, %0d renewed, %0d stored and %0d table-full responses",
               sb.tally[pkbt_pkg::OUTCOME_SUPPRESSED], sb.tally[pkbt_pkg::OUTCOME_RENEWED],
               sb.tally[pkbt_pkg::OUTCOME_NEW_STORED], sb.tally[pkbt_pkg::OUTCOME_TABLE_FULL]);
      $display("over %0d backoff settings, including zero, 65535 and a long response stall",
               settings_used);
      if (sb.mismatches == 0 && csr_faults == 0)
         $display("PASS per_key_report_backoff_table");
      else
         $display("FAIL per_key_report_backoff_table");
      $finish;
   end

   initial begin
      #200ms;
      $display("FAIL per_key_report_backoff_table");
      $finish;
   end
endmodule
